>>> rtl/core/tcc_pkg.sv
package tcc_pkg;

    // Geometry of the text grid in pixels, and the range of glyph codes
    localparam int GLYPH_WIDTH   = 6;
    localparam int LINE_SPACING  = 8;
    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 128;
    localparam int FIRST_GLYPH   = 32;
    localparam int GLYPH_COUNT   = 96;
    localparam int GLYPH_END     = FIRST_GLYPH + GLYPH_COUNT;

    localparam logic [7:0] GLYPH_W8     = 8'(GLYPH_WIDTH);
    localparam logic [7:0] HALF_SPACE8  = 8'(GLYPH_WIDTH / 2);
    localparam logic [7:0] SHORT_BS8    = 8'd3;
    localparam logic [7:0] LINE_SP8     = 8'(LINE_SPACING);
    localparam logic [8:0] SCREEN_W9    = 9'(SCREEN_WIDTH);
    localparam logic [8:0] SCREEN_H9    = 9'(SCREEN_HEIGHT);
    localparam logic [8:0] FIRST_GLYPH9 = 9'(FIRST_GLYPH);
    localparam logic [8:0] GLYPH_END9   = 9'(GLYPH_END);

    // RGB565 colours
    localparam logic [15:0] GREY_565  = 16'h8410;
    localparam logic [15:0] RED_565   = 16'hF800;
    localparam logic [15:0] GREEN_565 = 16'h07E0;
    localparam logic [15:0] BLUE_565  = 16'h001F;

    // Control codes
    localparam logic [7:0] CC_DELAY      = 8'd2;
    localparam logic [7:0] CC_HALF_SPACE = 8'd3;
    localparam logic [7:0] CC_SHORT_BS   = 8'd4;
    localparam logic [7:0] CC_INVERT     = 8'd7;
    localparam logic [7:0] CC_BACKSPACE  = 8'd8;
    localparam logic [7:0] CC_LINE_FEED  = 8'd10;
    localparam logic [7:0] CC_CLEAR      = 8'd12;
    localparam logic [7:0] CC_CR         = 8'd13;
    localparam logic [7:0] CC_GREY       = 8'd14;
    localparam logic [7:0] CC_TABX_LO    = 8'h80;
    localparam logic [7:0] CC_TABX_HI    = 8'h93;
    localparam logic [7:0] CC_TABY_LO    = 8'hA0;
    localparam logic [7:0] CC_TABY_HI    = 8'hAF;
    localparam logic [7:0] CC_COLOUR_LO  = 8'hC0;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_DRAW  = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_DELAY = 2'd3
    } action_t;

    // Configuration register indexes (byte address = 4 * index)
    typedef enum logic [1:0] {
        REG_DIVERT = 2'd0,
        REG_ECHO   = 2'd1,
        REG_KEEP   = 2'd2,
        REG_NONE   = 2'd3
    } reg_idx_t;

    function automatic logic [15:0] primary(input logic r, input logic g, input logic b);
        primary = (r ? RED_565 : 16'h0000) | (g ? GREEN_565 : 16'h0000)
                | (b ? BLUE_565 : 16'h0000);
    endfunction

endpackage

>>> rtl/core/tcc_char_if.sv
interface tcc_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

>>> rtl/core/tcc_cmd_if.sv
interface tcc_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [6:0]  glyph_index;
    logic [7:0]  draw_x;
    logic [7:0]  draw_y;
    logic [15:0] draw_fg;
    logic [15:0] draw_bg;
    logic        uart_valid;
    logic [7:0]  uart_byte;

    modport source (output valid, output action, output glyph_index, output draw_x,
                    output draw_y, output draw_fg, output draw_bg, output uart_valid,
                    output uart_byte, input ready);
    modport sink   (input valid, input action, input glyph_index, input draw_x,
                    input draw_y, input draw_fg, input draw_bg, input uart_valid,
                    input uart_byte, output ready);
endinterface

>>> rtl/core/text_cursor_control_engine.sv
// Text cursor control engine. Each beat on char_in carries one character code and
// produces exactly one command beat on cmd_out, in order: draw a glyph (index,
// pixel position, RGB565 colours), clear the screen with the background colour,
// a delay, or nothing. Control codes move the cursor or change the colours;
// printable codes draw and then advance the cursor with line and screen
// wrap. The block takes one character per clock: the decode and cursor update
// are a single short combinational step from the cursor/colour registers into
// the command register, and a new beat is taken whenever the command register is
// empty or being drained in the same cycle; a command follows in the cycle after
// its character and throughput is one beat per cycle. Three 1-bit APB registers
// (divert_enable at 0x0, uart_echo at 0x4, keep_screen at 0x8) control UART echo
// and suppression of screen processing; write them only while the engine is idle.
module text_cursor_control_engine (
    input  logic           clk,
    input  logic           rst_n,
    tcc_char_if.sink       char_in,
    tcc_cmd_if.source      cmd_out,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [3:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    // ---------------- configuration ----------------
    logic divert_reg, echo_reg, keep_reg;
    tcc_pkg::reg_idx_t reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = tcc_pkg::reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divert_reg <= 1'b0;
            echo_reg   <= 1'b0;
            keep_reg   <= 1'b0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_sel)
                tcc_pkg::REG_DIVERT: divert_reg <= pwdata[0];
                tcc_pkg::REG_ECHO:   echo_reg   <= pwdata[0];
                tcc_pkg::REG_KEEP:   keep_reg   <= pwdata[0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        unique case (reg_sel)
            tcc_pkg::REG_DIVERT: prdata[0] = divert_reg;
            tcc_pkg::REG_ECHO:   prdata[0] = echo_reg;
            tcc_pkg::REG_KEEP:   prdata[0] = keep_reg;
            default:             prdata = 32'd0;
        endcase
    end

    // ---------------- handshake ----------------
    logic out_valid_reg;
    logic accept;

    // command register frees up when empty or drained this cycle
    assign char_in.ready = !out_valid_reg || cmd_out.ready;
    assign accept        = char_in.valid && char_in.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (char_in.ready)
            out_valid_reg <= char_in.valid;
    end

    // ---------------- cursor / colour state ----------------
    logic [7:0]  cursor_x_reg, cursor_x_next;
    logic [7:0]  cursor_y_reg, cursor_y_next;
    logic [15:0] fore_reg, fore_next;
    logic [15:0] back_reg, back_next;

    // command payload
    tcc_pkg::action_t action_next;
    logic [6:0]  glyph_next;
    logic [7:0]  draw_x_next, draw_y_next, uart_byte_next;
    logic [15:0] draw_fg_next, draw_bg_next;
    logic        uart_valid_next;

    tcc_pkg::action_t action_reg;
    logic [6:0]  glyph_reg;
    logic [7:0]  draw_x_reg, draw_y_reg, uart_byte_reg;
    logic [15:0] draw_fg_reg, draw_bg_reg;
    logic        uart_valid_reg;

    logic [7:0] c;
    logic       screen_on;
    logic [7:0] x_adv, y_adv, x_tab, y_tab, y_line;
    logic [8:0] glyph_off;

    assign c = char_in.char_code;
    assign screen_on = !divert_reg || keep_reg;

    always_comb
    begin
        x_adv     = cursor_x_reg + tcc_pkg::GLYPH_W8;
        y_adv     = cursor_y_reg + tcc_pkg::LINE_SP8;
        // next line wraps to the top once past the bottom
        y_line    = ({1'b0, y_adv} >= tcc_pkg::SCREEN_H9) ? 8'd0 : y_adv;
        x_tab     = 8'({3'd0, c[4:0]} * tcc_pkg::GLYPH_W8);
        y_tab     = 8'({4'd0, c[3:0]} * tcc_pkg::LINE_SP8);
        glyph_off = {1'b0, c} - tcc_pkg::FIRST_GLYPH9;

        cursor_x_next   = cursor_x_reg;
        cursor_y_next   = cursor_y_reg;
        fore_next       = fore_reg;
        back_next       = back_reg;
        action_next     = tcc_pkg::ACT_NONE;
        glyph_next      = 7'd0;
        draw_x_next     = 8'd0;
        draw_y_next     = 8'd0;
        draw_fg_next    = 16'd0;
        draw_bg_next    = 16'd0;
        uart_valid_next = divert_reg && echo_reg;
        uart_byte_next  = (divert_reg && echo_reg) ? c : 8'd0;

        if (screen_on)
        begin
            priority if (c == tcc_pkg::CC_DELAY)
                action_next = tcc_pkg::ACT_DELAY;
            else if (c == tcc_pkg::CC_HALF_SPACE)
                cursor_x_next = cursor_x_reg + tcc_pkg::HALF_SPACE8;
            else if (c == tcc_pkg::CC_SHORT_BS)
                cursor_x_next = cursor_x_reg - tcc_pkg::SHORT_BS8;
            else if (c == tcc_pkg::CC_INVERT)
            begin
                fore_next = back_reg;
                back_next = fore_reg;
            end
            else if (c == tcc_pkg::CC_BACKSPACE)
            begin
                if (cursor_x_reg >= tcc_pkg::GLYPH_W8)
                    cursor_x_next = cursor_x_reg - tcc_pkg::GLYPH_W8;
            end
            else if (c == tcc_pkg::CC_LINE_FEED)
            begin
                cursor_x_next = 8'd0;
                cursor_y_next = y_line;
            end
            else if (c == tcc_pkg::CC_CLEAR)
            begin
                action_next   = tcc_pkg::ACT_CLEAR;
                draw_bg_next  = back_reg;
                cursor_x_next = 8'd0;
                cursor_y_next = 8'd0;
            end
            else if (c == tcc_pkg::CC_CR)
                cursor_x_next = 8'd0;
            else if (c == tcc_pkg::CC_GREY)
                fore_next = tcc_pkg::GREY_565;
            else if (c >= tcc_pkg::CC_TABX_LO && c <= tcc_pkg::CC_TABX_HI)
                cursor_x_next = x_tab;
            else if (c >= tcc_pkg::CC_TABY_LO && c <= tcc_pkg::CC_TABY_HI)
                cursor_y_next = y_tab;
            else if (c >= tcc_pkg::CC_COLOUR_LO)
            begin
                fore_next = tcc_pkg::primary(c[0], c[1], c[2]);
                back_next = tcc_pkg::primary(c[3], c[4], c[5]);
            end
            else if ({1'b0, c} >= tcc_pkg::FIRST_GLYPH9 && {1'b0, c} < tcc_pkg::GLYPH_END9)
            begin
                action_next  = tcc_pkg::ACT_DRAW;
                glyph_next   = glyph_off[6:0];
                draw_x_next  = cursor_x_reg;
                draw_y_next  = cursor_y_reg;
                draw_fg_next = fore_reg;
                draw_bg_next = back_reg;
                // advance, wrapping to the next line at the right edge
                if ({1'b0, x_adv} >= tcc_pkg::SCREEN_W9)
                begin
                    cursor_x_next = 8'd0;
                    cursor_y_next = y_line;
                end
                else
                    cursor_x_next = x_adv;
            end
            else
                action_next = tcc_pkg::ACT_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg <= 8'd0;
            cursor_y_reg <= 8'd0;
            fore_reg     <= 16'd0;
            back_reg     <= 16'd0;
        end
        else if (accept)
        begin
            cursor_x_reg <= cursor_x_next;
            cursor_y_reg <= cursor_y_next;
            fore_reg     <= fore_next;
            back_reg     <= back_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg     <= action_next;
            glyph_reg      <= glyph_next;
            draw_x_reg     <= draw_x_next;
            draw_y_reg     <= draw_y_next;
            draw_fg_reg    <= draw_fg_next;
            draw_bg_reg    <= draw_bg_next;
            uart_valid_reg <= uart_valid_next;
            uart_byte_reg  <= uart_byte_next;
        end
    end

    assign cmd_out.valid       = out_valid_reg;
    assign cmd_out.action      = action_reg;
    assign cmd_out.glyph_index = glyph_reg;
    assign cmd_out.draw_x      = draw_x_reg;
    assign cmd_out.draw_y      = draw_y_reg;
    assign cmd_out.draw_fg     = draw_fg_reg;
    assign cmd_out.draw_bg     = draw_bg_reg;
    assign cmd_out.uart_valid  = uart_valid_reg;
    assign cmd_out.uart_byte   = uart_byte_reg;

endmodule

>>> dv/tcc_cmd_checker.sv
`timescale 1ns / 1ps

module tcc_cmd_checker
    import tcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        char_valid,
    input  logic        char_ready,
    input  logic [7:0]  char_code,
    input  logic        cmd_valid,
    input  logic        cmd_ready,
    input  logic [1:0]  action,
    input  logic [6:0]  glyph_index,
    input  logic [7:0]  draw_x,
    input  logic [7:0]  draw_y,
    input  logic [15:0] draw_fg,
    input  logic [15:0] draw_bg,
    input  logic        uart_valid,
    input  logic [7:0]  uart_byte,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    output int          mismatches,
    output int          pending_beats
);

    typedef struct packed {
        action_t     action;
        logic [6:0]  glyph_index;
        logic [7:0]  draw_x;
        logic [7:0]  draw_y;
        logic [15:0] draw_fg;
        logic [15:0] draw_bg;
        logic        uart_valid;
        logic [7:0]  uart_byte;
    } draw_cmd_t;

    // Shadow of the cursor, colours and control bits
    logic [7:0]  cur_x     = '0;
    logic [7:0]  cur_y     = '0;
    logic [15:0] fg_colour = '0;
    logic [15:0] bg_colour = '0;
    logic        divert_on = 1'b0;
    logic        echo_on   = 1'b0;
    logic        keep_on   = 1'b0;

    draw_cmd_t pending_cmds [$];

    function automatic logic [15:0] rgb565(input logic r, input logic g, input logic b);
        return {{5{r}}, {6{g}}, {5{b}}};
    endfunction

    task automatic advance_line();
        cur_x = 8'd0;
        cur_y = cur_y + LINE_SP8;
        if ({1'b0, cur_y} >= SCREEN_H9)
            cur_y = 8'd0;
    endtask

    task automatic decode_char(input logic [7:0] c, output draw_cmd_t cmd);
        cmd = '0;
        if (divert_on)
        begin
            if (echo_on)
            begin
                cmd.uart_valid = 1'b1;
                cmd.uart_byte  = c;
            end
            if (!keep_on)
                return;
        end
        case (c)
            CC_DELAY:      cmd.action = ACT_DELAY;
            CC_HALF_SPACE: cur_x = cur_x + HALF_SPACE8;
            CC_SHORT_BS:   cur_x = cur_x - SHORT_BS8;
            CC_INVERT:
            begin
                {fg_colour, bg_colour} = {bg_colour, fg_colour};
            end
            CC_BACKSPACE:
            begin
                if (cur_x >= GLYPH_W8)
                    cur_x = cur_x - GLYPH_W8;
            end
            CC_LINE_FEED:  advance_line();
            CC_CLEAR:
            begin
                cmd.action  = ACT_CLEAR;
                cmd.draw_bg = bg_colour;
                cur_x       = 8'd0;
                cur_y       = 8'd0;
            end
            CC_CR:         cur_x = 8'd0;
            CC_GREY:       fg_colour = GREY_565;
            default:
            begin
                if (c >= CC_TABX_LO && c <= CC_TABX_HI)
                    cur_x = {3'b000, c[4:0]} * GLYPH_W8;
                else if (c >= CC_TABY_LO && c <= CC_TABY_HI)
                    cur_y = {4'b0000, c[3:0]} * LINE_SP8;
                else if (c >= CC_COLOUR_LO)
                begin
                    fg_colour = rgb565(c[0], c[1], c[2]);
                    bg_colour = rgb565(c[3], c[4], c[5]);
                end
                else if ({1'b0, c} >= FIRST_GLYPH9 && {1'b0, c} < GLYPH_END9)
                begin
                    cmd.action      = ACT_DRAW;
                    cmd.glyph_index = 7'(c - FIRST_GLYPH9[7:0]);
                    cmd.draw_x      = cur_x;
                    cmd.draw_y      = cur_y;
                    cmd.draw_fg     = fg_colour;
                    cmd.draw_bg     = bg_colour;
                    cur_x           = cur_x + GLYPH_W8;
                    if ({1'b0, cur_x} >= SCREEN_W9)
                        advance_line();
                end
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        draw_cmd_t want;
        draw_cmd_t next_cmd;
        logic      reg_bit;
        if (!rst_n)
        begin
            mismatches    = 0;
            pending_beats = 0;
        end
        else
        begin
            // Drain side first: a beat leaving now belongs to an older character
            if (cmd_valid && cmd_ready)
            begin
                if (pending_cmds.size() == 0)
                begin
                    $error("command beat with no character pending");
                    mismatches++;
                end
                else
                begin
                    want = pending_cmds.pop_front();
                    check_field("action", 32'(want.action), 32'(action));
                    check_field("glyph_index", 32'(want.glyph_index), 32'(glyph_index));
                    check_field("draw_x", 32'(want.draw_x), 32'(draw_x));
                    check_field("draw_y", 32'(want.draw_y), 32'(draw_y));
                    check_field("draw_fg", 32'(want.draw_fg), 32'(draw_fg));
                    check_field("draw_bg", 32'(want.draw_bg), 32'(draw_bg));
                    check_field("uart_valid", 32'(want.uart_valid), 32'(uart_valid));
                    check_field("uart_byte", 32'(want.uart_byte), 32'(uart_byte));
                end
            end
            if (char_valid && char_ready)
            begin
                decode_char(char_code, next_cmd);
                pending_cmds.push_back(next_cmd);
            end
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    case (reg_idx_t'(paddr[3:2]))
                        REG_DIVERT: divert_on = pwdata[0];
                        REG_ECHO:   echo_on   = pwdata[0];
                        REG_KEEP:   keep_on   = pwdata[0];
                        default:    ;
                    endcase
                end
                else if (reg_idx_t'(paddr[3:2]) != REG_NONE)
                begin
                    case (reg_idx_t'(paddr[3:2]))
                        REG_DIVERT: reg_bit = divert_on;
                        REG_ECHO:   reg_bit = echo_on;
                        default:    reg_bit = keep_on;
                    endcase
                    check_field("prdata", {31'b0, reg_bit}, prdata);
                end
            end
            pending_beats = pending_cmds.size();
        end
    end

endmodule

>>> dv/text_cursor_control_engine_tb.sv
`timescale 1ns / 1ps

module text_cursor_control_engine_tb;
    import tcc_pkg::*;

    // Worst case is far below this: ~710 chars, each with a sender gap and a
    // receiver stall at worst, plus six APB transfers per phase.
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_COUNT   = 9;
    localparam int CHARS_PER_PHASE = 85;

    // Directed opener, walked with all control bits clear:
    // colour set, glyph extremes, swap, clear with the swapped background,
    // grey, delay, line wrap off the right edge, screen wrap off the bottom,
    // backspace at the left margin, short backspace below zero and half
    // space wrapping back to zero, a draw at a wrapped cursor, tab extremes,
    // ignored codes and the byte extremes.
    localparam logic [7:0] DIRECTED_CODES [0:26] = '{
        8'hC7, 8'h20, 8'h7F, CC_INVERT, CC_CLEAR, CC_GREY, CC_DELAY,
        CC_TABX_HI, 8'h41, 8'h42, 8'h43,
        CC_TABY_HI, CC_LINE_FEED,
        CC_CR, CC_BACKSPACE, CC_SHORT_BS, CC_HALF_SPACE, CC_SHORT_BS, 8'h5A,
        CC_TABX_LO, CC_TABY_LO, 8'hF8,
        8'h00, 8'hFF, 8'h94, 8'hB0, 8'h1F
    };

    localparam logic [7:0] CTRL_CODES [0:8] = '{
        CC_DELAY, CC_HALF_SPACE, CC_SHORT_BS, CC_INVERT, CC_BACKSPACE,
        CC_LINE_FEED, CC_CLEAR, CC_CR, CC_GREY
    };

    // Control settings per phase as {divert, echo, keep}; phase 0 is the
    // directed part, the last two phases draw theirs at random.
    localparam logic [2:0] PHASE_CFG [0:PHASE_COUNT-1] = '{
        3'b000, 3'b000, 3'b100, 3'b110, 3'b111, 3'b101, 3'b011, 3'b000, 3'b111
    };

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int cycles = 0;
    int mismatches;
    int pending_beats;
    int burst_left;

    tcc_char_if char_bus ();
    tcc_cmd_if  cmd_bus ();

    text_cursor_control_engine u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .char_in (char_bus),
        .cmd_out (cmd_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    tcc_cmd_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .char_valid    (char_bus.valid),
        .char_ready    (char_bus.ready),
        .char_code     (char_bus.char_code),
        .cmd_valid     (cmd_bus.valid),
        .cmd_ready     (cmd_bus.ready),
        .action        (cmd_bus.action),
        .glyph_index   (cmd_bus.glyph_index),
        .draw_x        (cmd_bus.draw_x),
        .draw_y        (cmd_bus.draw_y),
        .draw_fg       (cmd_bus.draw_fg),
        .draw_bg       (cmd_bus.draw_bg),
        .uart_valid    (cmd_bus.uart_valid),
        .uart_byte     (cmd_bus.uart_byte),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .mismatches    (mismatches),
        .pending_beats (pending_beats)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog; also the time base for the receiver's stall pattern
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("text_cursor_control_engine_tb: FAIL");
            $finish;
        end
    end

    // Receiver: the pattern steps in turn between always ready, random drops,
    // a fixed 2-of-3 duty and bursts of long stalls, so stalls land on every
    // phase of the sender's bursts and gaps.
    initial
    begin
        int stall_left;
        int mode;
        cmd_bus.ready = 1'b0;
        stall_left    = 0;
        forever
        begin
            @(posedge clk);
            mode = (cycles / 113) % 4;
            if (stall_left > 0)
            begin
                cmd_bus.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                case (mode)
                    0: cmd_bus.ready <= 1'b1;
                    1: cmd_bus.ready <= ($urandom_range(0, 3) != 0);
                    2: cmd_bus.ready <= ((cycles % 3) != 0);
                    default:
                    begin
                        cmd_bus.ready <= 1'b1;
                        if ($urandom_range(0, 15) == 0)
                            stall_left = $urandom_range(2, 10);
                    end
                endcase
            end
        end
    end

    // Random character mix: printable codes most often so the cursor runs across and
    // down the screen, then control codes, tab positions, colour codes and
    // any byte at all (which covers the ignored codes).
    function automatic logic [7:0] pick_char();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 42)
            return 8'($urandom_range(FIRST_GLYPH, GLYPH_END - 1));
        else if (sel < 64)
            return CTRL_CODES[$urandom_range(0, 8)];
        else if (sel < 72)
            return 8'($urandom_range(CC_TABX_LO, CC_TABX_HI));
        else if (sel < 79)
            return 8'($urandom_range(CC_TABY_LO, CC_TABY_HI));
        else if (sel < 88)
            return 8'($urandom_range(CC_COLOUR_LO, 255));
        else
            return 8'($urandom_range(0, 255));
    endfunction

    // Called at a rising edge; returns at the edge the beat is taken,
    // with valid still high. ready is looked at on the falling edge, where
    // it is settled for the coming rising edge.
    task automatic send_char(input logic [7:0] code);
        char_bus.valid     <= 1'b1;
        char_bus.char_code <= code;
        @(negedge clk);
        while (!char_bus.ready)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Sender pacing: bursts of random length, occasionally long ones with no
    // idling at all, separated by random gaps.
    task automatic send_paced(input logic [7:0] code);
        send_char(code);
        if (burst_left == 0)
        begin
            char_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        else
            burst_left--;
    endtask

    // APB transfer: setup, access, then an idle state so back-to-back
    // transfers never drive psel twice in one step.
    task automatic apb_xfer(input logic wr, input reg_idx_t idx, input logic bit_val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= {31'b0, bit_val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [2:0] cfg);
        apb_xfer(1'b1, REG_DIVERT, cfg[2]);
        apb_xfer(1'b1, REG_ECHO,   cfg[1]);
        apb_xfer(1'b1, REG_KEEP,   cfg[0]);
        // Read back; the checker compares prdata with its shadow bits
        apb_xfer(1'b0, REG_DIVERT, 1'b0);
        apb_xfer(1'b0, REG_ECHO,   1'b0);
        apb_xfer(1'b0, REG_KEEP,   1'b0);
    endtask

    // Every character yields a command, so an empty expectation queue means
    // the engine is idle.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_beats != 0);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        logic [2:0] cfg;
        char_bus.valid     = 1'b0;
        char_bus.char_code = 8'h00;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        burst_left         = 0;
        rst_n              = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            wait_idle();
            cfg = (phase >= PHASE_COUNT - 2) ? 3'($urandom_range(0, 7)) : PHASE_CFG[phase];
            configure(cfg);
            if (phase == 0)
            begin
                foreach (DIRECTED_CODES[i])
                    send_paced(DIRECTED_CODES[i]);
            end
            else
            begin
                for (int k = 0; k < CHARS_PER_PHASE; k++)
                    send_paced(pick_char());
            end
            char_bus.valid <= 1'b0;
            @(posedge clk);
        end

        wait_idle();
        repeat (4) @(posedge clk);
        @(negedge clk);
        if (mismatches == 0)
            $display("text_cursor_control_engine_tb: PASS");
        else
            $display("text_cursor_control_engine_tb: FAIL");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/tcc_pkg.sv
rtl/core/tcc_char_if.sv
rtl/core/tcc_cmd_if.sv
rtl/core/text_cursor_control_engine.sv
dv/tcc_cmd_checker.sv
dv/text_cursor_control_engine_tb.sv
